// File: hw/rtl/tccw_pkg.sv
`timescale 1ns / 1ps

package tccw_pkg;

  // Operation codes carried in the opcode field
  localparam logic [2:0] OP_PUT_CHAR = 3'd0;
  localparam logic [2:0] OP_CLEAR    = 3'd1;
  localparam logic [2:0] OP_SET_CUR  = 3'd2;
  localparam logic [2:0] OP_FLUSH    = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  // Special characters and the default blank attribute
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] ATTR_DEFAULT = 8'h07;

  // Input transaction payload
  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  char_code;
    logic [3:0]  fg_color;
    logic [3:0]  back_color;
    logic [11:0] cell_position;
  } con_in_t;

  // Result transaction payload
  typedef struct packed {
    logic [10:0] cursor_cell;
    logic        dirty;
    logic        flush_due;
    logic        wrote_cell;
    logic [10:0] written_index;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic        position_rejected;
  } con_out_t;

endpackage

// File: hw/rtl/tccw_if.sv
`timescale 1ns / 1ps

// Input channel: valid/ready with a command payload
interface tccw_in_if;
  logic              valid;
  logic              ready;
  tccw_pkg::con_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Result channel: valid/ready with a status payload
interface tccw_out_if;
  logic               valid;
  logic               ready;
  tccw_pkg::con_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/text_console_cell_writer_top.sv
`timescale 1ns / 1ps
// Put char, set cursor, flush and unused codes go from ST_IDLE straight to ST_EXEC, which
// registers the result; read cell passes ST_READ, newline strips rows in ST_NEWLINE first.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Clear sweeps every cell in ST_CLEAR through the single cell-store write port first.
// Reset (rst_n low, synchronous) homes the cursor, drops the dirty flag and then sweeps
// every cell of the store to zero, during which no input transaction is taken.
module text_console_cell_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  tccw_in_if.sink          in_chan,
  tccw_out_if.source       out_chan
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CELL_W = $clog2(CELLS + 1);
  localparam int IDX_W = $clog2(CELLS);
  localparam int CMP_W = (CELL_W > 12) ? CELL_W : 12;

  localparam logic [CELL_W-1:0] CELLS_C   = CELL_W'(CELLS);
  localparam logic [CELL_W-1:0] COLS_C    = CELL_W'(COLUMNS);
  localparam logic [CELL_W-1:0] LAST_ROW  = CELL_W'(CELLS - COLUMNS);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CELLS - 1);
  localparam logic [CMP_W-1:0]  CELLS_CMP = CMP_W'(CELLS);

  typedef enum logic [5:0] {
    ST_INIT    = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_NEWLINE = 6'b000100,
    ST_CLEAR   = 6'b001000,
    ST_READ    = 6'b010000,
    ST_EXEC    = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CELL_W-1:0]   cursor_r, cursor_nxt;
  logic                dirty_r, dirty_nxt;
  logic [IDX_W-1:0]    addr_r, addr_nxt;
  logic [CELL_W-1:0]   rem_r, rem_nxt;
  logic [CELL_W-1:0]   base_r, base_nxt;
  tccw_pkg::con_in_t   cmd_r;
  tccw_pkg::con_out_t  out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [15:0]         mem [CELLS];
  logic [15:0]         rd_data_r;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [15:0]         mem_wd;
  logic [IDX_W-1:0]    rd_addr;

  logic                in_fire;
  logic                out_free;
  logic [7:0]          attr;
  logic                pos_ok;
  logic [CELL_W:0]     nl_sum;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign attr     = {cmd_r.back_color, cmd_r.fg_color};
  assign pos_ok   = CMP_W'(cmd_r.cell_position) < CELLS_CMP;
  assign nl_sum   = {1'b0, base_r} + {1'b0, COLS_C};
  assign rd_addr  = pos_ok ? IDX_W'(cmd_r.cell_position) : '0;

  assign in_chan.ready    = (state_r == ST_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  // Sequencer, row search, sweeps and result build
  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    dirty_nxt     = dirty_r;
    addr_nxt      = addr_r;
    rem_nxt       = rem_r;
    base_nxt      = base_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    mem_we        = 1'b0;
    mem_wa        = addr_r;
    mem_wd        = '0;

    unique case (state_r)
      ST_INIT: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        addr_nxt = '0;
        rem_nxt  = cursor_r;
        base_nxt = '0;
        if (in_fire) begin
          case (in_chan.payload.opcode)
            tccw_pkg::OP_PUT_CHAR: begin
              state_nxt = (in_chan.payload.char_code == tccw_pkg::CH_NEWLINE) ?
                          ST_NEWLINE : ST_EXEC;
            end
            tccw_pkg::OP_CLEAR: state_nxt = ST_CLEAR;
            tccw_pkg::OP_READ:  state_nxt = ST_READ;
            default:            state_nxt = ST_EXEC;
          endcase
        end
      end
      ST_NEWLINE: begin
        // strip one row per cycle until the remainder is inside a row
        if (rem_r >= COLS_C) begin
          rem_nxt  = rem_r - COLS_C;
          base_nxt = base_r + COLS_C;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_wd   = {tccw_pkg::ATTR_DEFAULT, tccw_pkg::CH_SPACE};
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_IDX) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          out_nxt = '0;
          case (cmd_r.opcode)
            tccw_pkg::OP_PUT_CHAR: begin
              dirty_nxt = 1'b1;
              if (cmd_r.char_code == tccw_pkg::CH_NEWLINE) begin
                cursor_nxt = (nl_sum >= {1'b0, CELLS_C}) ? LAST_ROW : nl_sum[CELL_W-1:0];
              end else if (cmd_r.char_code == tccw_pkg::CH_BACKSPACE) begin
                if (cursor_r != '0) begin
                  cursor_nxt            = cursor_r - 1'b1;
                  mem_we                = 1'b1;
                  mem_wa                = IDX_W'(cursor_nxt);
                  mem_wd                = {attr, tccw_pkg::CH_SPACE};
                  out_nxt.wrote_cell    = 1'b1;
                  out_nxt.written_index = 11'(CMP_W'(cursor_nxt));
                end
              end else if (cursor_r < CELLS_C) begin
                cursor_nxt            = cursor_r + 1'b1;
                mem_we                = 1'b1;
                mem_wa                = IDX_W'(cursor_r);
                mem_wd                = {attr, cmd_r.char_code};
                out_nxt.wrote_cell    = 1'b1;
                out_nxt.written_index = 11'(CMP_W'(cursor_r));
              end
            end
            tccw_pkg::OP_CLEAR: begin
              cursor_nxt = '0;
              dirty_nxt  = 1'b1;
            end
            tccw_pkg::OP_SET_CUR: begin
              if (pos_ok) begin
                cursor_nxt = CELL_W'(cmd_r.cell_position);
              end else begin
                out_nxt.position_rejected = 1'b1;
              end
            end
            tccw_pkg::OP_FLUSH: begin
              out_nxt.flush_due = dirty_r;
              dirty_nxt         = 1'b0;
            end
            tccw_pkg::OP_READ: begin
              if (pos_ok) begin
                out_nxt.read_char = rd_data_r[7:0];
                out_nxt.read_attr = rd_data_r[15:8];
              end
            end
            default: ;
          endcase
          out_nxt.cursor_cell = 11'(CMP_W'(cursor_nxt));
          out_nxt.dirty       = dirty_nxt;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cursor_r    <= '0;
      dirty_r     <= 1'b0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      dirty_r     <= dirty_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and row-search registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    base_r <= base_nxt;
    out_r  <= out_nxt;
    if (in_fire) begin
      cmd_r <= in_chan.payload;
    end
  end

  // Cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CELLS_C)
    else $error("cursor beyond end of store");

  a_written_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.wrote_cell |-> CMP_W'(out_r.written_index) < CELLS_CMP)
    else $error("written index outside store");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.flush_due |-> !out_r.dirty)
    else $error("flush left dirty flag set");

  a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> mem_we && (mem_wa == addr_r))
    else $error("clear sweep skipped a cell");
`endif

endmodule
